// ----- design/pmfa_pkg.sv -----
package pmfa_pkg;

  localparam int unsigned MemoryBytes = 64;
  localparam int unsigned FrameBytes  = 16;
  localparam int unsigned FrameCount  = MemoryBytes / FrameBytes;
  localparam int unsigned AddrW       = $clog2(MemoryBytes);
  localparam int unsigned OffsetW     = $clog2(FrameBytes);
  localparam int unsigned FrameW      = $clog2(FrameCount);
  localparam int unsigned SlotW       = $clog2(FrameCount);
  localparam int unsigned PidCount    = 4;
  localparam int unsigned PidW        = 2;
  localparam int unsigned ModeW       = 2;
  localparam int unsigned VpnW        = 2;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned StatusW     = 4;
  localparam int unsigned InDataW     = 16;
  localparam int unsigned OutDataW    = 24;

  typedef enum logic [ModeW-1:0] {
    MODE_MAP   = 2'd0,
    MODE_STORE = 2'd1,
    MODE_LOAD  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_MAPPED         = 4'd0,
    ST_UPDATED        = 4'd1,
    ST_STORED         = 4'd2,
    ST_LOADED         = 4'd3,
    ST_BAD_FLAG       = 4'd4,
    ST_NO_TABLE_FRAME = 4'd5,
    ST_NO_PAGE_FRAME  = 4'd6,
    ST_NOT_FOUND      = 4'd7,
    ST_READ_ONLY      = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    KIND_MAP    = 2'd0,
    KIND_STORE  = 2'd1,
    KIND_LOAD   = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    status_e              reject_status;
    logic [PidW-1:0]      pid;
    logic [VpnW-1:0]      vpn;
    logic [OffsetW-1:0]   offset;
    logic [ByteW-1:0]     value;
  } req_t;

  typedef struct packed {
    logic              any;
    logic [FrameW-1:0] frame;
  } frame_pick_t;

  function automatic frame_pick_t lowest_free(logic [FrameCount-1:0] free);
    frame_pick_t pick;
    pick.any   = |free;
    pick.frame = '0;
    for (int i = FrameCount - 1; i >= 0; i--) begin
      if (free[i]) begin
        pick.frame = FrameW'(i);
      end
    end
    return pick;
  endfunction

endpackage

// ----- design/pmfa_front.sv -----
module pmfa_front
  import pmfa_pkg::*;
(
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [ModeW-1:0]     s_mode_i,
  input  logic [InDataW-1:0]   s_data_i,
  output logic                 req_valid_o,
  input  logic                 req_ready_i,
  output req_t                 req_o
);

  logic [PidW-1:0]  pid;
  logic [AddrW-1:0] vaddr;
  logic [ByteW-1:0] value;

  assign pid   = s_data_i[PidW-1:0];
  assign vaddr = s_data_i[PidW+AddrW-1:PidW];
  assign value = s_data_i[PidW+AddrW+ByteW-1:PidW+AddrW];

  assign s_tready_o  = req_ready_i;
  assign req_valid_o = s_tvalid_i;

  always_comb begin
    req_o               = '0;
    req_o.pid           = pid;
    req_o.vpn           = vaddr[AddrW-1:OffsetW];
    req_o.offset        = vaddr[OffsetW-1:0];
    req_o.value         = value;
    req_o.reject_status = ST_NOT_FOUND;
    case (mode_e'(s_mode_i))
      MODE_MAP: begin
        if (value > ByteW'(1)) begin
          req_o.kind          = KIND_REJECT;
          req_o.reject_status = ST_BAD_FLAG;
        end else begin
          req_o.kind = KIND_MAP;
        end
      end
      MODE_STORE: req_o.kind = KIND_STORE;
      MODE_LOAD:  req_o.kind = KIND_LOAD;
      default:    req_o.kind = KIND_REJECT;
    endcase
  end

endmodule

// ----- design/pmfa_queue.sv -----
module pmfa_queue
  import pmfa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output req_t out_req_o
);

  req_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_req_o   = slot_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_ready_i & out_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- design/pmfa_back.sv -----
module pmfa_back
  import pmfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  req_t                  req_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [StatusW-1:0]    m_status_o,
  output logic [OutDataW-1:0]   m_data_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RD     = 7'b0000010,
    S_EVAL   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_DATA   = 7'b0010000,
    S_OUT    = 7'b0100000,
    S_SPARE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [ByteW-1:0]   mem_q [MemoryBytes];
  logic [MemoryBytes-1:0] mem_vld_q;
  logic [ByteW-1:0]   rd_data_q;
  logic               rd_vld_q;
  logic               mem_we, mem_re;
  logic [AddrW-1:0]   mem_addr;
  logic [ByteW-1:0]   mem_wdata;
  logic [ByteW-1:0]   rd_byte;

  logic [FrameCount-1:0] frame_free_q, frame_free_d;
  logic [PidCount-1:0]   table_valid_q, table_valid_d;
  logic [FrameW-1:0]     table_frame_q [PidCount];
  logic [FrameW-1:0]     table_frame_d [PidCount];

  req_t               req_q, req_d;
  logic [FrameW-1:0]  tbase_q, tbase_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic               skip_match_q, skip_match_d;
  logic               match_q, match_d;
  logic [SlotW-1:0]   match_slot_q, match_slot_d;
  logic [ByteW-1:0]   match_entry_q, match_entry_d;
  logic               zero_q, zero_d;
  logic [SlotW-1:0]   zero_slot_q, zero_slot_d;

  status_e            res_status_q, res_status_d;
  logic [ByteW-1:0]   res_rdata_q, res_rdata_d;
  logic [AddrW-1:0]   res_paddr_q, res_paddr_d;
  logic [FrameW-1:0]  res_fused_q, res_fused_d;
  logic               res_created_q, res_created_d;

  logic               out_valid_q;
  status_e            out_status_q;
  logic [ByteW-1:0]   out_rdata_q;
  logic [AddrW-1:0]   out_paddr_q;
  logic [FrameW-1:0]  out_fused_q;
  logic               out_created_q;
  logic               out_load;

  frame_pick_t        pick;
  logic [AddrW-1:0]   pa;

  assign rd_byte = rd_vld_q ? rd_data_q : '0;
  assign pick    = lowest_free(frame_free_q);
  assign pa      = {match_entry_q[FrameW:1], req_q.offset};

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    tbase_d       = tbase_q;
    slot_d        = slot_q;
    skip_match_d  = skip_match_q;
    match_d       = match_q;
    match_slot_d  = match_slot_q;
    match_entry_d = match_entry_q;
    zero_d        = zero_q;
    zero_slot_d   = zero_slot_q;
    res_status_d  = res_status_q;
    res_rdata_d   = res_rdata_q;
    res_paddr_d   = res_paddr_q;
    res_fused_d   = res_fused_q;
    res_created_d = res_created_q;
    frame_free_d  = frame_free_q;
    table_valid_d = table_valid_q;
    table_frame_d = table_frame_q;
    req_ready_o   = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = {tbase_q, {(OffsetW-SlotW){1'b0}}, slot_q};
    mem_wdata     = '0;
    out_load      = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d         = req_i;
          tbase_d       = table_frame_q[req_i.pid];
          slot_d        = '0;
          skip_match_d  = 1'b0;
          match_d       = 1'b0;
          zero_d        = 1'b0;
          res_status_d  = ST_NOT_FOUND;
          res_rdata_d   = '0;
          res_paddr_d   = '0;
          res_fused_d   = '0;
          res_created_d = 1'b0;
          case (req_i.kind)
            KIND_MAP: begin
              if (table_valid_q[req_i.pid]) begin
                state_d = S_RD;
              end else if (pick.any) begin
                frame_free_d[pick.frame]   = 1'b0;
                table_valid_d[req_i.pid]   = 1'b1;
                table_frame_d[req_i.pid]   = pick.frame;
                tbase_d                    = pick.frame;
                skip_match_d               = 1'b1;
                res_created_d              = 1'b1;
                state_d                    = S_RD;
              end else begin
                res_status_d = ST_NO_TABLE_FRAME;
                state_d      = S_OUT;
              end
            end
            KIND_STORE, KIND_LOAD: begin
              state_d = table_valid_q[req_i.pid] ? S_RD : S_OUT;
            end
            default: begin
              res_status_d = req_i.reject_status;
              state_d      = S_OUT;
            end
          endcase
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!match_q && !skip_match_q && rd_byte != '0 &&
            rd_byte[ByteW-1:3] == {{(ByteW-3-VpnW){1'b0}}, req_q.vpn}) begin
          match_d       = 1'b1;
          match_slot_d  = slot_q;
          match_entry_d = rd_byte;
        end
        if (!zero_q && rd_byte == '0) begin
          zero_d      = 1'b1;
          zero_slot_d = slot_q;
        end
        slot_d  = slot_q + SlotW'(1);
        state_d = (slot_q == SlotW'(FrameCount - 1)) ? S_DECIDE : S_RD;
      end
      S_DECIDE: begin
        state_d = S_OUT;
        case (req_q.kind)
          KIND_MAP: begin
            if (match_q) begin
              mem_we       = 1'b1;
              mem_addr     = {tbase_q, {(OffsetW-SlotW){1'b0}}, match_slot_q};
              mem_wdata    = {match_entry_q[ByteW-1:1], req_q.value[0]};
              res_status_d = ST_UPDATED;
            end else if (pick.any) begin
              frame_free_d[pick.frame] = 1'b0;
              mem_we       = zero_q;
              mem_addr     = {tbase_q, {(OffsetW-SlotW){1'b0}}, zero_slot_q};
              mem_wdata    = {{(ByteW-3-VpnW){1'b0}}, req_q.vpn, pick.frame,
                              req_q.value[0]};
              res_status_d = ST_MAPPED;
              res_fused_d  = pick.frame;
            end else begin
              res_status_d = ST_NO_PAGE_FRAME;
            end
          end
          KIND_STORE: begin
            if (!match_q) begin
              res_status_d = ST_NOT_FOUND;
            end else if (!match_entry_q[0]) begin
              res_status_d = ST_READ_ONLY;
            end else begin
              mem_we       = 1'b1;
              mem_addr     = pa;
              mem_wdata    = req_q.value;
              res_status_d = ST_STORED;
              res_paddr_d  = pa;
            end
          end
          KIND_LOAD: begin
            if (match_q) begin
              mem_re      = 1'b1;
              mem_addr    = pa;
              res_paddr_d = pa;
              state_d     = S_DATA;
            end else begin
              res_status_d = ST_NOT_FOUND;
            end
          end
          default: res_status_d = req_q.reject_status;
        endcase
      end
      S_DATA: begin
        res_rdata_d  = rd_byte;
        res_status_d = ST_LOADED;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    req_q         <= req_d;
    tbase_q       <= tbase_d;
    slot_q        <= slot_d;
    skip_match_q  <= skip_match_d;
    match_q       <= match_d;
    match_slot_q  <= match_slot_d;
    match_entry_q <= match_entry_d;
    zero_q        <= zero_d;
    zero_slot_q   <= zero_slot_d;
    res_status_q  <= res_status_d;
    res_rdata_q   <= res_rdata_d;
    res_paddr_q   <= res_paddr_d;
    res_fused_q   <= res_fused_d;
    res_created_q <= res_created_d;
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_rdata_q   <= res_rdata_q;
      out_paddr_q   <= res_paddr_q;
      out_fused_q   <= res_fused_q;
      out_created_q <= res_created_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      mem_vld_q     <= '0;
      rd_vld_q      <= 1'b0;
      frame_free_q  <= '1;
      table_valid_q <= '0;
      for (int i = 0; i < PidCount; i++) begin
        table_frame_q[i] <= '0;
      end
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      frame_free_q  <= frame_free_d;
      table_valid_q <= table_valid_d;
      table_frame_q <= table_frame_d;
      if (mem_we) begin
        mem_vld_q[mem_addr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= mem_vld_q[mem_addr];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_status_o = out_status_q;
  assign m_data_o   = {{(OutDataW-ByteW-AddrW-FrameW-1){1'b0}}, out_created_q,
                       out_fused_q, out_paddr_q, out_rdata_q};

endmodule

// ----- design/paged_mmu_with_frame_allocator.sv -----
// An item that skips the table scan (rejected, no page table, no free table frame)
//   goes straight to output; map, store and load scan the table, and load then reads
//   its data byte. The back end takes a new item only when idle; the four-slot scan
//   of the single-port memory (a read and an evaluate state per slot) dominates.
// Reset: asynchronous; all frames free, no page tables, every memory byte reads zero
//   through per-byte valid bits, so no clearing pass is needed.
module paged_mmu_with_frame_allocator
  import pmfa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,   // pid[1:0], virt_addr[7:2], value[15:8]
  input  logic [ModeW-1:0]     s_axis_tuser,   // mode[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,   // read_data[7:0], phys_addr[13:8],
                                               // frame_used[15:14], table_created[16]
  output logic [StatusW-1:0]   m_axis_tuser    // status[3:0]
);

  logic front_valid, front_ready;
  req_t front_req;
  logic back_valid, back_ready;
  req_t back_req;

  pmfa_front u_front (
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_mode_i    (s_axis_tuser),
    .s_data_i    (s_axis_tdata),
    .req_valid_o (front_valid),
    .req_ready_i (front_ready),
    .req_o       (front_req)
  );

  pmfa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_req_i    (front_req),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready),
    .out_req_o   (back_req)
  );

  pmfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (back_valid),
    .req_ready_o (back_ready),
    .req_i       (back_req),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_status_o  (m_axis_tuser),
    .m_data_o    (m_axis_tdata)
  );

endmodule
